// File: rtl/lass_pkg.sv
package lass_pkg;

    localparam int DefPositionWidth = 18;
    localparam int DefTimeWidth     = 32;

    localparam logic [3:0] MODE_TICK  = 4'd0;
    localparam logic [3:0] MODE_HELLO = 4'd1;
    localparam logic [3:0] MODE_HB    = 4'd2;
    localparam logic [3:0] MODE_STAT  = 4'd3;
    localparam logic [3:0] MODE_STOP  = 4'd4;
    localparam logic [3:0] MODE_CLEAR = 4'd5;
    localparam logic [3:0] MODE_HOME  = 4'd6;
    localparam logic [3:0] MODE_ARM   = 4'd7;
    localparam logic [3:0] MODE_SET   = 4'd8;

    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_REL_LOWER = 2'd1;
    localparam logic [1:0] ST_REL_UPPER = 2'd2;
    localparam logic [1:0] ST_SEEK      = 2'd3;

    localparam logic [2:0] F_NONE    = 3'd0;
    localparam logic [2:0] F_COMM    = 3'd1;
    localparam logic [2:0] F_BOTH    = 3'd2;
    localparam logic [2:0] F_HTIME   = 3'd3;
    localparam logic [2:0] F_RELEASE = 3'd4;
    localparam logic [2:0] F_ENDSTOP = 3'd5;

    localparam logic [1:0] REP_NONE = 2'd0;
    localparam logic [1:0] REP_ACK  = 2'd1;
    localparam logic [1:0] REP_ERR  = 2'd2;

    localparam logic [3:0] E_SESSION = 4'd0;
    localparam logic [3:0] E_STALE   = 4'd1;
    localparam logic [3:0] E_REUSE   = 4'd2;
    localparam logic [3:0] E_LIMITS  = 4'd3;
    localparam logic [3:0] E_FAULTED = 4'd4;
    localparam logic [3:0] E_NOTHOME = 4'd5;
    localparam logic [3:0] E_NOTARM  = 4'd6;
    localparam logic [3:0] E_RANGE   = 4'd7;
    localparam logic [3:0] E_LIMACT  = 4'd8;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_REL_LO   = 3'd1;
    localparam logic [2:0] EV_REL_UP   = 3'd2;
    localparam logic [2:0] EV_SEEK     = 3'd3;
    localparam logic [2:0] EV_HOMED    = 3'd4;
    localparam logic [2:0] EV_REL_FAIL = 3'd5;
    localparam logic [2:0] EV_HTIME    = 3'd6;
    localparam logic [2:0] EV_COMM     = 3'd7;

    localparam logic [2:0] SC_FAULT  = 3'd0;
    localparam logic [2:0] SC_WAIT   = 3'd1;
    localparam logic [2:0] SC_HOMING = 3'd2;
    localparam logic [2:0] SC_DISARM = 3'd3;
    localparam logic [2:0] SC_IDLE   = 3'd4;
    localparam logic [2:0] SC_MOVING = 3'd5;

    localparam logic [2:0] MC_NONE = 3'd0;
    localparam logic [2:0] MC_HOLD = 3'd1;
    localparam logic [2:0] MC_MOVE = 3'd2;
    localparam logic [2:0] MC_UP   = 3'd3;
    localparam logic [2:0] MC_DOWN = 3'd4;
    localparam logic [2:0] MC_LOAD = 3'd5;

    localparam logic [2:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [2:0] CFG_WATCHDOG = 3'd1;
    localparam logic [2:0] CFG_HTIMEOUT = 3'd2;
    localparam logic [2:0] CFG_RTIMEOUT = 3'd3;
    localparam logic [2:0] CFG_RTRAVEL  = 3'd4;
    localparam logic [2:0] CFG_TOL      = 3'd5;
    localparam logic [2:0] CFG_MAX      = 3'd6;
    localparam logic [2:0] CFG_LEVEL    = 3'd7;

endpackage

// File: rtl/lift_axis_safety_supervisor.sv
// Lift axis safety supervisor.
// The input channel (i_valid/o_ready) carries one word per tick or decoded
// command; each accepted word yields exactly one result word on the output
// channel (o_valid/i_ready) carrying reply, event, status and motion command.
// A tick debounces both limit switches, checks the end stops, advances the
// homing stages and runs the watchdog and homing timers; a command is
// checked for session, sequence, fault, homing, arming, range and end-stop direction.
// A result is registered and presented in the cycle after its word is
// accepted. Throughput is one word per cycle while the receiver is ready,
// set by the single pass of state update logic between the supervisor state
// registers and the result register. While the receiver stalls, the result
// is held; a new word is accepted only when it is taken in the same cycle.
// The user must write configuration through i_cfg_we/i_cfg_index/i_cfg_data
// only while the block is idle (unchecked here); indices beyond the list are ignored.
// Synchronous active-low reset restores the register defaults, clears all
// faults, flags and the session, and empties the result register.
module lift_axis_safety_supervisor
    import lass_pkg::*;
#(
    parameter int POSITION_WIDTH = DefPositionWidth,
    parameter int TIME_WIDTH     = DefTimeWidth
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [2:0]                       i_cfg_index,
    input  logic [17:0]                      i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [3:0]                       i_mode,
    input  logic [31:0]                      i_now_ms,
    input  logic                             i_raw_lower,
    input  logic                             i_raw_upper,
    input  logic signed [POSITION_WIDTH-1:0] i_position,
    input  logic [31:0]                      i_session,
    input  logic [31:0]                      i_sequence_req,
    input  logic signed [POSITION_WIDTH-1:0] i_target_steps,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_reply,
    output logic [3:0]                       o_reply_code,
    output logic [2:0]                       o_event_res,
    output logic [2:0]                       o_state_code,
    output logic [2:0]                       o_fault_code,
    output logic                             o_homed,
    output logic                             o_armed,
    output logic [2:0]                       o_motion_cmd,
    output logic signed [POSITION_WIDTH-1:0] o_motion_value,
    output logic                             o_lower_limit,
    output logic                             o_upper_limit
);

    localparam int PW = POSITION_WIDTH;
    localparam int TW = TIME_WIDTH;
    // Wide enough for positions and the 17-bit travel limits with sign.
    localparam int AW = ((PW > 18) ? PW : 18) + 2;

    // Configuration registers.
    logic [7:0]  r_debounce;
    logic [15:0] r_watchdog;
    logic [17:0] r_htimeout;
    logic [15:0] r_rtimeout;
    logic [15:0] r_rtravel;
    logic [15:0] r_tol;
    logic [16:0] r_max;
    logic        r_level;

    // Supervisor state.
    logic [1:0]          r_stable, n_stable;
    logic [1:0]          r_cand, n_cand;
    logic [TW-1:0]       r_since0, n_since0, r_since1, n_since1;
    logic [2:0]          r_fault, n_fault;
    logic                r_homed, n_homed, r_armed, n_armed, r_homing, n_homing;
    logic [1:0]          r_stage, n_stage;
    logic                r_sact, n_sact;
    logic [31:0]         r_sid, n_sid, r_retired, n_retired;
    logic                r_seq_seen, n_seq_seen;
    logic [31:0]         r_last_seq, n_last_seq;
    logic [TW-1:0]       r_last_cmd, n_last_cmd, r_hstart, n_hstart, r_sstart, n_sstart;
    logic signed [PW-1:0] r_rel_pos, n_rel_pos, r_target, n_target;

    // Result register.
    logic                r_ovalid;
    logic [1:0]          r_reply, n_reply;
    logic [3:0]          r_code, n_code;
    logic [2:0]          r_ev, n_ev;
    logic [2:0]          r_sc, n_sc;
    logic [2:0]          r_mc, n_mc;
    logic signed [PW-1:0] r_mv, n_mv;

    logic                    accept;
    logic [TW-1:0]           now;
    logic signed [PW-1:0]    cur;
    logic signed [AW-1:0]    cur_w, tol_w, max_w, tgt_w, dist_w;
    logic [31:0]             seq_d;

    assign o_ready = !r_ovalid || i_ready;
    assign accept  = i_valid && o_ready;
    assign now     = i_now_ms[TW-1:0];
    assign cur_w   = AW'(i_position);
    assign tol_w   = AW'({1'b0, r_tol});
    assign max_w   = AW'({1'b0, r_max});
    assign tgt_w   = AW'(i_target_steps);
    assign seq_d   = i_sequence_req - r_last_seq;

    always_comb begin
        logic lo, up, s;
        lo = 1'b0; up = 1'b0; s = 1'b0;
        n_stable = r_stable;  n_cand = r_cand;
        n_since0 = r_since0;  n_since1 = r_since1;
        n_fault = r_fault;    n_homed = r_homed;  n_armed = r_armed;
        n_homing = r_homing;  n_stage = r_stage;  n_sact = r_sact;
        n_sid = r_sid;        n_retired = r_retired;
        n_seq_seen = r_seq_seen; n_last_seq = r_last_seq;
        n_last_cmd = r_last_cmd; n_hstart = r_hstart; n_sstart = r_sstart;
        n_rel_pos = r_rel_pos;   n_target = r_target;
        n_reply = REP_NONE; n_code = E_SESSION; n_ev = EV_NONE;
        n_mc = MC_NONE; n_mv = '0;
        cur = i_position;
        dist_w = '0;

        if (i_mode == MODE_TICK) begin
            // Debounce, one switch at a time.
            s = i_raw_lower;
            if (s != r_cand[0]) begin
                n_cand[0] = s; n_since0 = now;
            end else if (r_stable[0] != r_cand[0]
                         && (now - r_since0) >= TW'(r_debounce)) begin
                n_stable[0] = r_cand[0];
            end
            s = i_raw_upper;
            if (s != r_cand[1]) begin
                n_cand[1] = s; n_since1 = now;
            end else if (r_stable[1] != r_cand[1]
                         && (now - r_since1) >= TW'(r_debounce)) begin
                n_stable[1] = r_cand[1];
            end
            lo = (n_stable[0] == r_level);
            up = (n_stable[1] == r_level);

            // End stops and homing stages.
            if (lo && up) begin
                n_target = cur;
                if (n_mc != MC_LOAD) begin n_mc = MC_HOLD; n_mv = cur; end
                n_armed = 1'b0; n_homing = 1'b0; n_stage = ST_NONE; n_homed = 1'b0;
                n_fault = F_BOTH;
            end else if (r_homing) begin
                if ((r_stage == ST_REL_LOWER || r_stage == ST_SEEK) && up) begin
                    n_target = cur; n_mc = MC_HOLD; n_mv = cur;
                    n_armed = 1'b0; n_homing = 1'b0; n_stage = ST_NONE;
                    n_homed = 1'b0;
                    if (r_fault == F_NONE) n_fault = F_RELEASE;
                    n_ev = EV_REL_FAIL;
                end else if ((r_stage == ST_REL_LOWER && !lo)
                             || (r_stage == ST_REL_UPPER && !up)) begin
                    n_target = cur; n_stage = ST_SEEK; n_sstart = now;
                    n_mc = MC_DOWN; n_mv = '0; n_ev = EV_SEEK;
                end else if (r_stage == ST_SEEK && lo) begin
                    cur = '0; n_target = '0; n_mc = MC_LOAD; n_mv = '0;
                    n_homed = 1'b1; n_homing = 1'b0; n_stage = ST_NONE;
                    n_armed = 1'b0; n_ev = EV_HOMED;
                end
            end else if (r_armed) begin
                if ((lo && cur_w > tol_w) || (up && cur_w < max_w - tol_w)) begin
                    n_target = cur; n_mc = MC_HOLD; n_mv = cur;
                    n_armed = 1'b0; n_homing = 1'b0; n_stage = ST_NONE;
                    n_homed = 1'b0;
                    if (r_fault == F_NONE) n_fault = F_ENDSTOP;
                end else if (lo && r_target < cur) begin
                    cur = '0; n_target = '0; n_mc = MC_LOAD; n_mv = '0;
                end else if (up && r_target > cur) begin
                    cur = PW'(max_w); n_target = cur; n_mc = MC_LOAD; n_mv = cur;
                end
            end

            // Watchdog.
            if (r_sact && (n_armed || n_homing)
                && (now - r_last_cmd) > TW'(r_watchdog)) begin
                n_target = cur;
                if (n_mc != MC_LOAD) begin n_mc = MC_HOLD; n_mv = cur; end
                n_armed = 1'b0; n_homing = 1'b0; n_stage = ST_NONE;
                if (n_fault == F_NONE) n_fault = F_COMM;
                if (r_sid != 32'd0) n_retired = r_sid;
                n_sact = 1'b0; n_sid = '0; n_seq_seen = 1'b0; n_last_seq = '0;
                n_ev = EV_COMM;
            end

            // Homing motion and timers.
            if (n_fault == F_NONE && n_homing) begin
                if (n_stage == ST_REL_LOWER || n_stage == ST_REL_UPPER) begin
                    dist_w = cur_w - AW'(n_rel_pos);
                    if (dist_w < 0) dist_w = -dist_w;
                    if (dist_w > AW'({1'b0, r_rtravel})
                        || (now - n_sstart) > TW'(r_rtimeout)) begin
                        n_target = cur;
                        if (n_mc != MC_LOAD) begin n_mc = MC_HOLD; n_mv = cur; end
                        n_armed = 1'b0; n_homing = 1'b0; n_stage = ST_NONE;
                        n_homed = 1'b0; n_fault = F_RELEASE; n_ev = EV_REL_FAIL;
                    end else begin
                        n_mc = (n_stage == ST_REL_LOWER) ? MC_UP : MC_DOWN;
                        n_mv = '0;
                    end
                end else if ((now - r_hstart) > TW'(r_htimeout)) begin
                    n_target = cur;
                    if (n_mc != MC_LOAD) begin n_mc = MC_HOLD; n_mv = cur; end
                    n_armed = 1'b0; n_homing = 1'b0; n_stage = ST_NONE;
                    n_homed = 1'b0; n_fault = F_HTIME; n_ev = EV_HTIME;
                end else begin
                    n_mc = MC_DOWN; n_mv = '0;
                end
            end
        end else if (i_mode == MODE_HELLO) begin
            n_target = cur; n_mc = MC_HOLD; n_mv = cur;
            n_armed = 1'b0; n_homing = 1'b0; n_stage = ST_NONE;
            if (r_sact && i_session == r_sid) begin
                n_last_cmd = now; n_reply = REP_ACK;
            end else if (i_session == 32'd0 || i_session == r_retired) begin
                n_reply = REP_ERR; n_code = E_REUSE;
            end else begin
                if (r_sact) n_retired = r_sid;
                n_sid = i_session; n_sact = 1'b1; n_seq_seen = 1'b0;
                n_last_seq = '0; n_last_cmd = now; n_reply = REP_ACK;
            end
        end else if (i_mode <= MODE_SET) begin
            lo = (r_stable[0] == r_level);
            up = (r_stable[1] == r_level);
            if (!r_sact || i_session != r_sid) begin
                n_reply = REP_ERR; n_code = E_SESSION;
            end else if (r_seq_seen && !(seq_d != 32'd0 && !seq_d[31])) begin
                n_reply = REP_ERR; n_code = E_STALE;
            end else begin
                n_seq_seen = 1'b1; n_last_seq = i_sequence_req; n_reply = REP_ACK;
                case (i_mode) inside
                    MODE_HB: n_last_cmd = now;
                    MODE_STOP, MODE_CLEAR: begin
                        n_target = cur; n_mc = MC_HOLD; n_mv = cur;
                        n_armed = 1'b0; n_homing = 1'b0; n_stage = ST_NONE;
                        if (i_mode == MODE_STOP) n_last_cmd = now;
                        else if (lo && up) begin
                            n_reply = REP_ERR; n_code = E_LIMITS;
                        end else begin
                            n_fault = F_NONE; n_last_cmd = now;
                        end
                    end
                    MODE_HOME, MODE_ARM, MODE_SET: begin
                        if (r_fault != F_NONE) begin
                            n_reply = REP_ERR; n_code = E_FAULTED;
                        end else if (i_mode == MODE_HOME) begin
                            n_last_cmd = now; n_target = cur;
                            n_armed = 1'b0; n_homed = 1'b0; n_homing = 1'b1;
                            n_hstart = now; n_sstart = now; n_mv = '0;
                            if (lo) begin
                                n_stage = ST_REL_LOWER; n_rel_pos = cur;
                                n_mc = MC_UP; n_ev = EV_REL_LO;
                            end else if (up) begin
                                n_stage = ST_REL_UPPER; n_rel_pos = cur;
                                n_mc = MC_DOWN; n_ev = EV_REL_UP;
                            end else begin
                                n_stage = ST_SEEK; n_mc = MC_DOWN; n_ev = EV_SEEK;
                            end
                        end else if (i_mode == MODE_ARM) begin
                            if (!r_homed) begin
                                n_reply = REP_ERR; n_code = E_NOTHOME;
                            end else begin
                                n_armed = 1'b1; n_homing = 1'b0; n_stage = ST_NONE;
                                n_target = cur; n_mc = MC_MOVE; n_mv = cur;
                                n_last_cmd = now;
                            end
                        end else if (!r_armed || !r_homed) begin
                            n_reply = REP_ERR; n_code = E_NOTARM;
                        end else if (tgt_w < 0 || tgt_w > max_w) begin
                            n_reply = REP_ERR; n_code = E_RANGE;
                        end else if ((tgt_w < cur_w && lo) || (tgt_w > cur_w && up)) begin
                            n_reply = REP_ERR; n_code = E_LIMACT;
                        end else begin
                            n_target = i_target_steps; n_mc = MC_MOVE;
                            n_mv = i_target_steps; n_last_cmd = now;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (n_fault != F_NONE)  n_sc = SC_FAULT;
        else if (!n_sact)       n_sc = SC_WAIT;
        else if (n_homing)      n_sc = SC_HOMING;
        else if (!n_armed)      n_sc = SC_DISARM;
        else                    n_sc = (n_target == cur) ? SC_IDLE : SC_MOVING;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= 8'd15;   r_watchdog <= 16'd300;
            r_htimeout <= 18'd65000; r_rtimeout <= 16'd5000;
            r_rtravel <= 16'd2500; r_tol <= 16'd1000;
            r_max <= 17'd52000;    r_level <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data[7:0];
                CFG_WATCHDOG: r_watchdog <= i_cfg_data[15:0];
                CFG_HTIMEOUT: r_htimeout <= i_cfg_data;
                CFG_RTIMEOUT: r_rtimeout <= i_cfg_data[15:0];
                CFG_RTRAVEL:  r_rtravel  <= i_cfg_data[15:0];
                CFG_TOL:      r_tol      <= i_cfg_data[15:0];
                CFG_MAX:      r_max      <= i_cfg_data[16:0];
                CFG_LEVEL:    r_level    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 2'b00; r_cand <= 2'b00;
            r_since0 <= '0; r_since1 <= '0;
            r_fault <= F_NONE; r_homed <= 1'b0; r_armed <= 1'b0; r_homing <= 1'b0;
            r_stage <= ST_NONE; r_sact <= 1'b0; r_sid <= '0; r_retired <= '0;
            r_seq_seen <= 1'b0; r_last_seq <= '0; r_last_cmd <= '0;
            r_hstart <= '0; r_sstart <= '0; r_rel_pos <= '0; r_target <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_stable <= n_stable; r_cand <= n_cand;
                r_since0 <= n_since0; r_since1 <= n_since1;
                r_fault <= n_fault; r_homed <= n_homed; r_armed <= n_armed;
                r_homing <= n_homing; r_stage <= n_stage; r_sact <= n_sact;
                r_sid <= n_sid; r_retired <= n_retired;
                r_seq_seen <= n_seq_seen; r_last_seq <= n_last_seq;
                r_last_cmd <= n_last_cmd; r_hstart <= n_hstart; r_sstart <= n_sstart;
                r_rel_pos <= n_rel_pos; r_target <= n_target;
            end
            if (accept) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    // The switch stable levels reset to the inactive level of the default
    // polarity, which is active high, so zero is inactive.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_reply <= n_reply;
            r_code  <= (n_reply == REP_ERR) ? n_code : E_SESSION;
            r_ev    <= n_ev;
            r_sc    <= n_sc;
            r_mc    <= n_mc;
            r_mv    <= n_mv;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_reply        = r_reply;
    assign o_reply_code   = r_code;
    assign o_event_res    = r_ev;
    assign o_state_code   = r_sc;
    assign o_fault_code   = r_fault;
    assign o_homed        = r_homed;
    assign o_armed        = r_armed;
    assign o_motion_cmd   = r_mc;
    assign o_motion_value = r_mv;
    assign o_lower_limit  = (r_stable[0] == r_level);
    assign o_upper_limit  = (r_stable[1] == r_level);

    a_no_fault_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault != F_NONE |-> !r_armed)
        else $error("armed while a fault is latched");
    a_armed_not_homing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_armed && r_homing))
        else $error("armed and homing together");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_mc) && $stable(r_reply))
        else $error("result changed under stall");
    a_homing_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_homing |-> r_stage != ST_NONE)
        else $error("homing without a stage");

endmodule
